FILE: hdl/sphd_pkg.sv
// Shared types and constants for the solenoid peak-and-hold driver.
// Used by every module of the block; depends on nothing.
package sphd_pkg;

  localparam int CHANNELS_DEF = 6;
  localparam int DUTY_FIELDS  = 6;
  localparam int ROAD_W       = 4;
  localparam int TICK_W       = 16;
  localparam int DUTY_W       = 8;
  localparam int PCT_W        = 7;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [DUTY_W-1:0] FULL_DUTY = 8'd255;
  localparam logic [TICK_W-1:0] TICK_MAX  = 16'hFFFF;

  localparam logic [TICK_W-1:0] PULL_IN_RST   = 16'd100;
  localparam logic [PCT_W-1:0]  HOLD_PCT_RST  = 7'd50;
  localparam logic [DUTY_W-1:0] HOLD_DUTY_RST = 8'd127;

  // floor(pct*255/100) == (pct * 255 * 5243) >> 19 for every 7-bit pct
  localparam int HOLD_PROD_W = 28;
  localparam int HOLD_SHIFT  = 19;
  localparam logic [HOLD_PROD_W-1:0] HOLD_MUL = 28'd1336965;

  localparam logic [ADDR_W-1:0] ADDR_PULL_IN  = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_HOLD_PCT = 3'd4;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_SET     = 2'd1,
    CMD_ALL_OFF = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ROAD_W-1:0] road;
    logic              want_open;
  } in_req_t;

  typedef struct packed {
    logic              accepted;
    logic              road_open;
    logic [DUTY_W-1:0] duty_0;
    logic [DUTY_W-1:0] duty_1;
    logic [DUTY_W-1:0] duty_2;
    logic [DUTY_W-1:0] duty_3;
    logic [DUTY_W-1:0] duty_4;
    logic [DUTY_W-1:0] duty_5;
  } out_rsp_t;

  typedef struct packed {
    logic fire;
    cmd_t cmd;
    logic sel;
    logic want_open;
  } chan_ctl_t;

endpackage

FILE: hdl/sphd_cfg_regs.sv
// APB-style configuration registers: pull-in time and hold percent.
// Also holds the registered hold duty derived from the percent. Uses sphd_pkg.
module sphd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sphd_pkg::ADDR_W-1:0]     paddr,
  input  logic [sphd_pkg::DATA_W-1:0]     pwdata,
  output logic [sphd_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  output logic [sphd_pkg::TICK_W-1:0]     pull_in_ticks,
  output logic [sphd_pkg::DUTY_W-1:0]     hold_duty
);

  logic [sphd_pkg::TICK_W-1:0]      pull_in_r;
  logic [sphd_pkg::PCT_W-1:0]       hold_pct_r;
  logic [sphd_pkg::DUTY_W-1:0]      hold_duty_r, hold_duty_nxt;
  logic [sphd_pkg::HOLD_PROD_W-1:0] hold_prod;
  logic [sphd_pkg::HOLD_PROD_W-sphd_pkg::HOLD_SHIFT-1:0] hold_raw;
  logic                             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  assign hold_prod = sphd_pkg::HOLD_PROD_W'(hold_pct_r) * sphd_pkg::HOLD_MUL;
  assign hold_raw  = hold_prod[sphd_pkg::HOLD_PROD_W-1:sphd_pkg::HOLD_SHIFT];

  always_comb begin
    if (hold_raw > (sphd_pkg::HOLD_PROD_W-sphd_pkg::HOLD_SHIFT)'(sphd_pkg::FULL_DUTY)) begin
      hold_duty_nxt = sphd_pkg::FULL_DUTY;
    end else begin
      hold_duty_nxt = hold_raw[sphd_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pull_in_r   <= sphd_pkg::PULL_IN_RST;
      hold_pct_r  <= sphd_pkg::HOLD_PCT_RST;
      hold_duty_r <= sphd_pkg::HOLD_DUTY_RST;
    end else begin
      hold_duty_r <= hold_duty_nxt;
      if (wr_en) begin
        if (paddr[2] == sphd_pkg::ADDR_HOLD_PCT[2]) begin
          hold_pct_r <= pwdata[sphd_pkg::PCT_W-1:0];
        end else begin
          pull_in_r <= pwdata[sphd_pkg::TICK_W-1:0];
        end
      end
    end
  end

  always_comb begin
    if (paddr[2] == sphd_pkg::ADDR_HOLD_PCT[2]) begin
      prdata = sphd_pkg::DATA_W'(hold_pct_r);
    end else begin
      prdata = sphd_pkg::DATA_W'(pull_in_r);
    end
  end

  assign pull_in_ticks = pull_in_r;
  assign hold_duty     = hold_duty_r;

endmodule

FILE: hdl/sphd_channel.sv
// One valve channel: open flag, elapsed tick counter and drive duty.
// Applies one request per cycle while ctl.fire is high and exposes the post-request state. Uses sphd_pkg.
module sphd_channel (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sphd_pkg::chan_ctl_t         ctl,
  input  logic [sphd_pkg::TICK_W-1:0] pull_in_ticks,
  input  logic [sphd_pkg::DUTY_W-1:0] hold_duty,
  output logic                        open_nxt,
  output logic [sphd_pkg::DUTY_W-1:0] duty_nxt
);

  logic                        open_r;
  logic [sphd_pkg::TICK_W-1:0] elapsed_r, elapsed_nxt;
  logic [sphd_pkg::DUTY_W-1:0] duty_r;

  always_comb begin
    open_nxt    = open_r;
    elapsed_nxt = elapsed_r;
    duty_nxt    = duty_r;
    if (ctl.fire) begin
      unique case (ctl.cmd)
        sphd_pkg::CMD_TICK: begin
          if (open_r) begin
            if (elapsed_r != sphd_pkg::TICK_MAX) begin
              elapsed_nxt = elapsed_r + 1'b1;
            end
            if (elapsed_nxt >= pull_in_ticks) begin
              duty_nxt = hold_duty;
            end
          end
        end
        sphd_pkg::CMD_SET: begin
          if (ctl.sel && (open_r != ctl.want_open)) begin
            open_nxt    = ctl.want_open;
            elapsed_nxt = '0;
            duty_nxt    = ctl.want_open ? sphd_pkg::FULL_DUTY : '0;
          end
        end
        sphd_pkg::CMD_ALL_OFF: begin
          open_nxt    = 1'b0;
          elapsed_nxt = '0;
          duty_nxt    = '0;
        end
        sphd_pkg::CMD_QUERY: begin
          open_nxt = open_r;
        end
        default: begin
          open_nxt = open_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      elapsed_r <= '0;
      duty_r    <= '0;
    end else begin
      open_r    <= open_nxt;
      elapsed_r <= elapsed_nxt;
      duty_r    <= duty_nxt;
    end
  end

endmodule

FILE: hdl/solenoid_peak_hold_driver.sv
// Top level of the solenoid peak-and-hold driver.
// Instantiates sphd_cfg_regs and one sphd_channel per channel. Uses sphd_pkg.
//
// Usage:
//   in_valid/in_ready carry one request: tick, set, all-off or query.
//   out_valid/out_ready return one response per request: accepted flag,
//   open state of the named channel and the duty of channels 1 to 6.
//   cfg_* is an APB-style port: pull-in ticks at 0x0, hold percent at 0x4.
// Latency: the response is valid in the cycle after the request is taken.
// Throughput: one request per cycle while no response is stalled; the channel update
//   and response capture happen in the same cycle from the channel next-state values.
// Stall: while a response waits with out_ready low, in_ready is low; it
//   rises again in the cycle the response is taken, so a request can be
//   taken in that same cycle.
// Reset: all channels closed with zero duty and counter, pull-in 100 ticks,
//   hold 50 percent; no response pending.
// Configuration changes reach the hold duty through the hold percent register, then the hold duty register.
module solenoid_peak_hold_driver #(
  parameter int CHANNELS = sphd_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sphd_pkg::in_req_t               in_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sphd_pkg::out_rsp_t              out_rsp,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sphd_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [sphd_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [sphd_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                            cfg_pready
);

  logic [sphd_pkg::TICK_W-1:0] pull_in_ticks;
  logic [sphd_pkg::DUTY_W-1:0] hold_duty;
  logic                        fire;
  logic                        road_valid;
  logic                        out_valid_r, out_valid_nxt;
  sphd_pkg::out_rsp_t          out_rsp_r, out_rsp_nxt;
  logic [CHANNELS-1:0]         sel;
  logic [CHANNELS-1:0]         open_nxt;
  logic [sphd_pkg::DUTY_W-1:0] duty_nxt [CHANNELS];
  logic [sphd_pkg::DUTY_W-1:0] duty_pad [sphd_pkg::DUTY_FIELDS];

  sphd_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .pull_in_ticks (pull_in_ticks),
    .hold_duty     (hold_duty)
  );

  assign in_ready   = !out_valid_r || out_ready;
  assign fire       = in_valid && in_ready;
  assign road_valid = (in_req.road != '0) &&
                      (in_req.road <= sphd_pkg::ROAD_W'(CHANNELS));

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    sphd_pkg::chan_ctl_t ctl;

    assign sel[i]        = (in_req.road == sphd_pkg::ROAD_W'(i + 1));
    assign ctl.fire      = fire;
    assign ctl.cmd       = in_req.cmd;
    assign ctl.sel       = sel[i];
    assign ctl.want_open = in_req.want_open;

    sphd_channel u_chan (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .pull_in_ticks (pull_in_ticks),
      .hold_duty     (hold_duty),
      .open_nxt      (open_nxt[i]),
      .duty_nxt      (duty_nxt[i])
    );
  end

  for (genvar k = 0; k < sphd_pkg::DUTY_FIELDS; k++) begin : g_pad
    if (k < CHANNELS) begin : g_live
      assign duty_pad[k] = duty_nxt[k];
    end else begin : g_none
      assign duty_pad[k] = '0;
    end
  end

  always_comb begin
    out_rsp_nxt.accepted = 1'b1;
    if ((in_req.cmd == sphd_pkg::CMD_SET) || (in_req.cmd == sphd_pkg::CMD_QUERY)) begin
      out_rsp_nxt.accepted = road_valid;
    end
    out_rsp_nxt.road_open = road_valid && |(sel & open_nxt);
    out_rsp_nxt.duty_0    = duty_pad[0];
    out_rsp_nxt.duty_1    = duty_pad[1];
    out_rsp_nxt.duty_2    = duty_pad[2];
    out_rsp_nxt.duty_3    = duty_pad[3];
    out_rsp_nxt.duty_4    = duty_pad[4];
    out_rsp_nxt.duty_5    = duty_pad[5];
  end

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_alloff_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_req.cmd == sphd_pkg::CMD_ALL_OFF) |=>
      !out_rsp.road_open && (out_rsp.duty_0 == '0) && (out_rsp.duty_5 == '0))
    else $error("all-off left a channel driven");

  a_bad_road: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !road_valid |=> !out_rsp.road_open)
    else $error("open reported for an invalid channel");

  a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("taken request produced no response");

  a_open_full: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_req.cmd == sphd_pkg::CMD_SET) && road_valid && in_req.want_open &&
      !(|(sel & open_nxt)) |-> 1'b0)
    else $error("set-open did not open the channel");

endmodule

FILE: dv/solenoid_peak_hold_driver_tb.sv
// Self-checking testbench for solenoid_peak_hold_driver: directed and random requests,
// register writes with readback, and a tick run that moves the hold level of an open valve.
// Depends on sphd_pkg and the RTL in hdl/ only.
module solenoid_peak_hold_driver_tb;
  import sphd_pkg::*;

  localparam int NCH         = CHANNELS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int BLOCKS      = 14;
  localparam int BLOCK_REQS  = 72;
  localparam int SOAK_TICKS  = 20;

  class valve_duty_tracker;
    logic [TICK_W-1:0] pull_in;
    logic [PCT_W-1:0]  hold_pct;
    bit                valve_open [NCH];
    logic [TICK_W-1:0] elapsed [NCH];
    logic [DUTY_W-1:0] duty [NCH];
    out_rsp_t          awaited_rsp [$];
    int                mismatches;
    int                requests;
    int                responses;

    function new();
      pull_in  = PULL_IN_RST;
      hold_pct = HOLD_PCT_RST;
      for (int i = 0; i < NCH; i++) begin
        drive(i, 1'b0);
      end
    endfunction

    function void drive(int i, bit open);
      valve_open[i] = open;
      elapsed[i]    = '0;
      duty[i]       = open ? FULL_DUTY : '0;
    endfunction

    function logic [DUTY_W-1:0] hold_duty();
      int unsigned h;
      h = hold_pct * 255 / 100;
      return (h > 255) ? FULL_DUTY : DUTY_W'(h);
    endfunction

    function void write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] v);
      if (addr == ADDR_PULL_IN) pull_in = v[TICK_W-1:0];
      else if (addr == ADDR_HOLD_PCT) hold_pct = v[PCT_W-1:0];
    endfunction

    function logic [DATA_W-1:0] reg_value(logic [ADDR_W-1:0] addr);
      if (addr == ADDR_PULL_IN) return DATA_W'(pull_in);
      return DATA_W'(hold_pct);
    endfunction

    function int pending();
      return awaited_rsp.size();
    endfunction

    function void note_request(in_req_t r);
      out_rsp_t          exp_rsp;
      bit                valid;
      int                idx;
      logic [DUTY_W-1:0] h;
      valid = (r.road >= 1) && (r.road <= NCH);
      idx   = valid ? int'(r.road) - 1 : 0;
      exp_rsp = '0;
      exp_rsp.accepted = 1'b1;
      case (r.cmd)
        CMD_TICK: begin
          h = hold_duty();
          for (int i = 0; i < NCH; i++) begin
            if (valve_open[i]) begin
              if (elapsed[i] != TICK_MAX) elapsed[i] = elapsed[i] + 1'b1;
              if (elapsed[i] >= pull_in) duty[i] = h;
            end
          end
        end
        CMD_SET: begin
          if (!valid) exp_rsp.accepted = 1'b0;
          else if (valve_open[idx] != r.want_open) drive(idx, r.want_open);
        end
        CMD_ALL_OFF: begin
          for (int i = 0; i < NCH; i++) begin
            drive(i, 1'b0);
          end
        end
        default: begin
          if (!valid) exp_rsp.accepted = 1'b0;
        end
      endcase
      exp_rsp.road_open = valid && valve_open[idx];
      exp_rsp.duty_0 = duty[0];
      exp_rsp.duty_1 = duty[1];
      exp_rsp.duty_2 = duty[2];
      exp_rsp.duty_3 = duty[3];
      exp_rsp.duty_4 = duty[4];
      exp_rsp.duty_5 = duty[5];
      awaited_rsp.push_back(exp_rsp);
      requests++;
    endfunction

    function logic [DUTY_W-1:0] duty_of(out_rsp_t r, int i);
      case (i)
        0: return r.duty_0;
        1: return r.duty_1;
        2: return r.duty_2;
        3: return r.duty_3;
        4: return r.duty_4;
        default: return r.duty_5;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_response(out_rsp_t got);
      out_rsp_t want;
      if (awaited_rsp.size() == 0) begin
        report($sformatf("response with nothing outstanding: %h", got));
      end else begin
        want = awaited_rsp.pop_front();
        if (got.accepted !== want.accepted)
          report($sformatf("response %0d accepted: got %b, want %b",
                           responses, got.accepted, want.accepted));
        if (got.road_open !== want.road_open)
          report($sformatf("response %0d road_open: got %b, want %b",
                           responses, got.road_open, want.road_open));
        for (int i = 0; i < NCH; i++) begin
          if (duty_of(got, i) !== duty_of(want, i))
            report($sformatf("response %0d duty_%0d: got %0d, want %0d",
                             responses, i, duty_of(got, i), duty_of(want, i)));
        end
      end
      responses++;
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_req_t             in_req;
  logic                out_valid;
  logic                out_ready;
  out_rsp_t            out_rsp;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [DATA_W-1:0]   cfg_pwdata;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  valve_duty_tracker book = new();
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_left;
  int cycle_count;
  int reg_writes;

  solenoid_peak_hold_driver #(.CHANNELS(NCH)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rsp     (out_rsp),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding",
               cycle_count, book.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Response side: check, then pick next cycle's ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_response(out_rsp);
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_req_t req(cmd_t cmd, int road, bit want_open);
    in_req_t r;
    r.cmd       = cmd;
    r.road      = ROAD_W'(road);
    r.want_open = want_open;
    return r;
  endfunction

  function automatic in_req_t random_request();
    int      pick;
    int      road;
    cmd_t    cmd;
    pick = $urandom_range(99);
    if (pick < 38) cmd = CMD_TICK;
    else if (pick < 72) cmd = CMD_SET;
    else if (pick < 77) cmd = CMD_ALL_OFF;
    else cmd = CMD_QUERY;
    if ((cmd == CMD_SET || cmd == CMD_QUERY) && $urandom_range(9) != 0)
      road = $urandom_range(NCH, 1);
    else
      road = $urandom_range(15);
    return req(cmd, road, 1'($urandom_range(1)));
  endfunction

  task send_request(in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_request(r);
  endtask

  // Drop valid and hold until every outstanding response is back.
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  task cfg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rdata;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    book.write_reg(addr, value);
    reg_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    if (rdata !== book.reg_value(addr))
      book.report($sformatf("readback at %0h: got %0h, want %0h",
                            addr, rdata, book.reg_value(addr)));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random upper bits check that the registers keep only their own width.
  task set_regs(int pull_in, int hold_pct);
    cfg_write(ADDR_PULL_IN, {16'($urandom), 16'(pull_in)});
    cfg_write(ADDR_HOLD_PCT, {25'($urandom), 7'(hold_pct)});
  endtask

  task run_directed();
    send_request(req(CMD_QUERY, 0, 1'b1));
    send_request(req(CMD_SET, 0, 1'b1));
    send_request(req(CMD_SET, NCH + 1, 1'b1));
    send_request(req(CMD_SET, 15, 1'b1));
    send_request(req(CMD_QUERY, 15, 1'b0));
    send_request(req(CMD_SET, 1, 1'b1));
    send_request(req(CMD_SET, 1, 1'b1));
    send_request(req(CMD_SET, NCH, 1'b1));
    send_request(req(CMD_TICK, NCH, 1'b0));
    send_request(req(CMD_QUERY, NCH, 1'b1));
    send_request(req(CMD_SET, NCH, 1'b0));
    send_request(req(CMD_SET, NCH, 1'b0));
    send_request(req(CMD_ALL_OFF, 1, 1'b1));
    send_request(req(CMD_TICK, 15, 1'b1));
    drain();
    set_regs(0, 127);
    send_request(req(CMD_SET, 2, 1'b1));
    send_request(req(CMD_TICK, 2, 1'b1));
    send_request(req(CMD_SET, 3, 1'b1));
    drain();
    set_regs(0, 0);
    send_request(req(CMD_TICK, 0, 1'b0));
    drain();
    set_regs(2, 100);
    send_request(req(CMD_SET, 4, 1'b1));
    send_request(req(CMD_TICK, 4, 1'b0));
    send_request(req(CMD_TICK, 3, 1'b1));
    send_request(req(CMD_QUERY, 4, 1'b0));
    send_request(req(CMD_SET, 2, 1'b0));
    send_request(req(CMD_ALL_OFF, 0, 1'b0));
    drain();
  endtask

  task run_random();
    int pull_in;
    int hold_pct;
    for (int b = 0; b < BLOCKS; b++) begin
      case (b)
        0: begin pull_in = 0;     hold_pct = 0;   end
        1: begin pull_in = 65535; hold_pct = 100; end
        2: begin pull_in = 1;     hold_pct = 127; end
        3: begin pull_in = 3;     hold_pct = 101; end
        default: begin
          pull_in  = ($urandom_range(5) == 0) ? $urandom_range(65535) : $urandom_range(6);
          hold_pct = $urandom_range(1) ? $urandom_range(127) : $urandom_range(100);
        end
      endcase
      if (b < 5) begin
        send_idle_pct = 23;
        recv_idle_pct = 63;
      end else if (b < 10) begin
        send_idle_pct = 63;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_regs(pull_in, hold_pct);
      if (b == 3) hold_off_left = 120;
      for (int n = 0; n < BLOCK_REQS; n++) begin
        send_request(random_request());
      end
      drain();
    end
  endtask

  // Hold one valve open past pull-in, then move the hold level under it.
  task run_saturation();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(10, 50);
    send_request(req(CMD_ALL_OFF, 5, 1'b1));
    send_request(req(CMD_SET, 5, 1'b1));
    for (int n = 0; n < SOAK_TICKS; n++) begin
      send_request(req(CMD_TICK, $urandom_range(15), 1'($urandom_range(1))));
    end
    drain();
    set_regs(10, 100);
    send_request(req(CMD_TICK, 5, 1'b0));
    send_request(req(CMD_QUERY, 5, 1'b1));
    send_request(req(CMD_SET, 1, 1'b1));
    send_request(req(CMD_TICK, 1, 1'b0));
    drain();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req        <= '0;
    out_ready     <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    send_idle_pct = 23;
    recv_idle_pct = 63;
    hold_off_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    run_saturation();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests and %0d responses across %0d register writes,",
             book.requests, book.responses, reg_writes);
    $display("including a %0d-tick hold run on one valve; %0d mismatches.",
             SOAK_TICKS, book.mismatches);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
